// ===== rtl/core/fbfl_pkg.sv =====
// Shared types, widths and codes for the fixed block free-list allocator.
package fbfl_pkg;

  // Field widths
  localparam int CNT_W     = 11;
  localparam int HANDLE_W  = 10;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Size of the handle space that the handle fields can address
  localparam int HANDLE_SPACE = 1024;

  // Default number of block handles
  localparam int FBFL_CAPACITY = 1024;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROW_STEP = 2'd2;

  // Configuration reset values
  localparam logic [CNT_W-1:0] INIT_CAP_RST  = 11'd16;
  localparam logic [CNT_W-1:0] MAX_CAP_RST   = 11'd1024;
  localparam logic [CNT_W-1:0] GROW_STEP_RST = 11'd64;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle_in;
  } item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic                failed;
    logic [CNT_W-1:0]    live_count;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // request transfer this cycle
    logic link_load;  // load list head from link memory read data
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop;        // current request takes a handle off the free list
  } dp_status_t;

endpackage

// ===== rtl/core/fbfl_ram.sv =====
// Generic simple dual-port RAM with registered read.
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/fbfl_ctrl.sv =====
// Controller: request acceptance and the link memory wait state.
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LINK = 1'b1;

  logic state;
  logic state_next;

  assign busy          = (state == ST_LINK);
  assign cmd.accept    = start && (state == ST_IDLE);
  assign cmd.link_load = (state == ST_LINK);

  // A pop waits in ST_LINK for the next link to come back
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept && status.pop) begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/fbfl_dp.sv =====
// Datapath: counters, limit growth, free-list head and link memory.
module fbfl_dp
  import fbfl_pkg::*;
#(
  parameter int CAPACITY = FBFL_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  item_t                item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  output logic                 done,
  output result_t              result
);

  localparam int SPACE = (CAPACITY < HANDLE_SPACE) ? CAPACITY : HANDLE_SPACE;
  localparam int AW    = (SPACE > 1) ? $clog2(SPACE) : 1;
  localparam logic [CNT_W-1:0] SPACE_W   = CNT_W'(SPACE);
  localparam logic [CNT_W-1:0] CEIL_RST  = (MAX_CAP_RST < SPACE_W) ? MAX_CAP_RST : SPACE_W;
  localparam logic [CNT_W-1:0] LIMIT_RST = (INIT_CAP_RST < CEIL_RST) ? INIT_CAP_RST : CEIL_RST;

  // Configuration registers
  logic [CNT_W-1:0] init_cap;
  logic [CNT_W-1:0] max_cap;
  logic [CNT_W-1:0] grow_step;

  // Allocator state
  logic [HANDLE_W-1:0] next_free;
  logic [HANDLE_W-1:0] next_free_next;
  logic [CNT_W-1:0]    touched;
  logic [CNT_W-1:0]    touched_next;
  logic [CNT_W-1:0]    live;
  logic [CNT_W-1:0]    live_next;
  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    limit_next;
  result_t             result_next;

  logic [CNT_W-1:0] ceil_val;
  logic [CNT_W-1:0] step_lo;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] limit_grown;
  logic             at_limit;
  logic             grow_ok;
  logic             cap_fail;
  logic             bump;
  logic             bump_fail;
  logic             free_fail;
  logic             is_alloc;
  logic             is_free;

  logic                ram_we;
  logic                ram_re;
  logic [HANDLE_W-1:0] ram_rdata;

  // Effective ceiling and growth of the committed limit
  assign ceil_val    = (max_cap < SPACE_W) ? max_cap : SPACE_W;
  assign at_limit    = (live >= limit);
  assign step_lo     = (limit < grow_step) ? limit : grow_step;
  assign room        = ceil_val - limit;
  assign step        = (step_lo > room) ? room : step_lo;
  assign grow_ok     = (limit < ceil_val) && (step != '0);
  assign limit_grown = limit + step;

  assign is_alloc  = (item.kind == KIND_ALLOC);
  assign is_free   = (item.kind == KIND_FREE);
  assign cap_fail  = at_limit && !grow_ok;
  assign bump      = (live == touched);
  assign bump_fail = (touched >= ceil_val);
  assign free_fail = (live == '0) || ({1'b0, item.handle_in} >= SPACE_W);

  assign status.pop = is_alloc && !cap_fail && !bump;

  // Link memory: free pushes the old head, pop reads the next one
  assign ram_we = cmd.accept && is_free && !free_fail;
  assign ram_re = cmd.accept && status.pop;

  fbfl_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (SPACE)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item.handle_in[AW-1:0]),
    .wdata (next_free),
    .re    (ram_re),
    .raddr (next_free[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Next state and result of the request in transfer
  always_comb begin
    next_free_next         = next_free;
    touched_next           = touched;
    live_next              = live;
    limit_next             = limit;
    result_next.handle_out = '0;
    result_next.failed     = 1'b0;
    if (cmd.link_load) begin
      next_free_next = ram_rdata;
    end
    if (cmd.accept) begin
      case (item.kind)
        KIND_ALLOC: begin
          if (cap_fail) begin
            result_next.failed = 1'b1;
          end else begin
            if (at_limit) begin
              limit_next = limit_grown;
            end
            if (bump) begin
              if (bump_fail) begin
                result_next.failed = 1'b1;
              end else begin
                result_next.handle_out = touched[HANDLE_W-1:0];
                touched_next           = touched + 1'b1;
                live_next              = live + 1'b1;
              end
            end else begin
              result_next.handle_out = next_free;
              live_next              = live + 1'b1;
            end
          end
        end
        KIND_FREE: begin
          if (free_fail) begin
            result_next.failed = 1'b1;
          end else begin
            next_free_next = item.handle_in;
            live_next      = live - 1'b1;
          end
        end
        KIND_CLEAR: begin
          next_free_next = '0;
          touched_next   = '0;
          live_next      = '0;
          limit_next     = (init_cap < ceil_val) ? init_cap : ceil_val;
        end
        default: begin
        end
      endcase
    end
    result_next.live_count = live_next;
  end

  // Control and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cap  <= INIT_CAP_RST;
      max_cap   <= MAX_CAP_RST;
      grow_step <= GROW_STEP_RST;
      next_free <= '0;
      touched   <= '0;
      live      <= '0;
      limit     <= LIMIT_RST;
      done      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_CAP:  init_cap  <= cfg_data;
          REG_MAX_CAP:   max_cap   <= cfg_data;
          REG_GROW_STEP: grow_step <= cfg_data;
          default: begin
          end
        endcase
      end
      next_free <= next_free_next;
      touched   <= touched_next;
      live      <= live_next;
      limit     <= limit_next;
      done      <= cmd.accept;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/core/fixed_block_free_list_allocator.sv =====
// Top level of the fixed block free-list allocator.
//
// Request channel: item (kind, handle_in) transfers at a clock edge with
// start high and busy low. Kinds: allocate, free, clear; the fourth code
// does nothing but still returns a result.
// Result channel: one result per request, on result for exactly one cycle
// with done high, in the cycle after the request transfer. The receiver
// cannot stall; every result is taken as it appears.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Indexes 0..2 select initial capacity, maximum
// capacity and grow step; other indexes are dropped. Write only when idle.
// Free, clear and failed or fresh allocations never raise busy.
// An allocation that reuses a freed handle also passes through the link
// wait state: the link memory read of the next list entry is registered,
// and busy is high while the list head is loaded from it.
// Reset (rst, synchronous): empty allocator, default configuration, limit
// at initial capacity, or the ceiling if lower. Link memory contents are not
// cleared; entries are always written by a free before the list reads them.
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int CAPACITY = FBFL_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  fbfl_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  fbfl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  // Busy always falls in the cycle after it is raised
  assert property (@(posedge clk) disable iff (rst) busy |=> !busy)
    else $error("busy held for more than one cycle");

  // Each request transfer gives exactly one result strobe
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("request transfer without result");

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without request transfer");

  // Only a list pop enters the wait state
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (item.kind == KIND_ALLOC)))
    else $error("wait state entered without an allocation");

  // A refused request carries no handle
  assert property (@(posedge clk) disable iff (rst)
    (done && result.failed) |-> (result.handle_out == '0))
    else $error("failed result carries a handle");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for the fixed block free-list allocator: directed table, then checked random phases.
`timescale 1ns / 100ps

module tb;
  import fbfl_pkg::*;

  // Unused fourth kind code: the block returns a result and does nothing else
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_LIMIT  = 500;
  localparam int SETTLE_CYCLES = 3;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CNT_W-1:0]     data;
    item_t                req;
    bit                   typed;
    result_t              want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  item_t                item = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 busy;
  logic                 done;
  logic                 cfg_ready;
  result_t              result;

  // Predicted allocator state and registers
  logic [CNT_W-1:0]    p_init_cap;
  logic [CNT_W-1:0]    p_max_cap;
  logic [CNT_W-1:0]    p_grow_step;
  logic [HANDLE_W-1:0] p_head;
  logic [CNT_W-1:0]    p_touched;
  logic [CNT_W-1:0]    p_live;
  logic [CNT_W-1:0]    p_limit;
  logic [HANDLE_W-1:0] p_link [FBFL_CAPACITY];

  result_t             owed_results [$];
  logic [HANDLE_W-1:0] held_handles [$];
  plan_row_t           plan [$];
  int                  errors = 0;
  int                  quiet_cycles = 0;
  int                  sent_items = 0;

  fixed_block_free_list_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Committed-block ceiling: smallest of max capacity, the block capacity and the handle space
  function automatic logic [CNT_W-1:0] block_ceiling();
    logic [CNT_W-1:0] c;
    c = p_max_cap;
    if (c > FBFL_CAPACITY) c = CNT_W'(FBFL_CAPACITY);
    if (c > HANDLE_SPACE) c = CNT_W'(HANDLE_SPACE);
    return c;
  endfunction

  function automatic void empty_pool();
    logic [CNT_W-1:0] c;
    c = block_ceiling();
    p_head    = '0;
    p_touched = '0;
    p_live    = '0;
    p_limit   = (p_init_cap < c) ? p_init_cap : c;
  endfunction

  // Expected result of one request; advances the predicted state
  function automatic result_t predict_request(item_t req);
    result_t          r;
    logic [CNT_W-1:0] c;
    logic [CNT_W-1:0] diff;
    r = '0;
    c = block_ceiling();
    case (req.kind)
      KIND_ALLOC: begin
        // grow the limit when it is reached
        if (p_live >= p_limit && p_limit < c) begin
          diff = (p_limit < p_grow_step) ? p_limit : p_grow_step;
          if (diff > c - p_limit) diff = c - p_limit;
          p_limit = p_limit + diff;
        end
        if (p_live >= p_limit) begin
          r.failed = 1'b1;
        end else if (p_live == p_touched) begin
          if (p_touched >= c) begin
            r.failed = 1'b1;
          end else begin
            r.handle_out = p_touched[HANDLE_W-1:0];
            p_touched    = p_touched + 1'b1;
            p_live       = p_live + 1'b1;
          end
        end else begin
          r.handle_out = p_head;
          p_head       = p_link[p_head];
          p_live       = p_live + 1'b1;
        end
      end
      KIND_FREE: begin
        if (p_live == '0) begin
          r.failed = 1'b1;
        end else begin
          p_link[req.handle_in] = p_head;
          p_head = req.handle_in;
          p_live = p_live - 1'b1;
        end
      end
      KIND_CLEAR: empty_pool();
      default: ;
    endcase
    r.live_count = p_live;
    return r;
  endfunction

  // Request transfer; the typed expectation replaces the prediction when given
  task automatic send_request(input item_t req, input bit typed, input result_t want);
    result_t r;
    start <= 1'b1;
    item  <= req;
    do @(posedge clk); while (!(start && !busy));
    r = predict_request(req);
    owed_results.push_back(typed ? want : r);
    if (req.kind == KIND_ALLOC && !r.failed) held_handles.push_back(r.handle_out);
    if (req.kind == KIND_CLEAR) held_handles.delete();
    sent_items++;
  endtask

  // Register transfer; the caller lowers cfg_valid after the last one
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_INIT_CAP:  p_init_cap  = data;
      REG_MAX_CAP:   p_max_cap   = data;
      REG_GROW_STEP: p_grow_step = data;
      default: ;
    endcase
  endtask

  // Stop requests, let every result drain and the pipeline settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void plan_chk(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] h,
                                   logic [HANDLE_W-1:0] ho, logic f, logic [CNT_W-1:0] lc);
    plan_row_t row;
    row = '{default: '0};
    row.req   = '{kind: kind, handle_in: h};
    row.typed = 1'b1;
    row.want  = '{handle_out: ho, failed: f, live_count: lc};
    plan.push_back(row);
  endfunction

  function automatic void plan_op(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] h);
    plan_row_t row;
    row = '{default: '0};
    row.req = '{kind: kind, handle_in: h};
    plan.push_back(row);
  endfunction

  function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    plan.push_back(row);
  endfunction

  // Random request: alloc or free of a held handle, with some noise
  function automatic item_t pick_request(int bias);
    item_t req;
    int    r;
    int    k;
    r = $urandom_range(0, 99);
    req.handle_in = HANDLE_W'($urandom_range(0, HANDLE_SPACE - 1));
    if (r < bias) begin
      req.kind = KIND_ALLOC;
    end else if (r < 93) begin
      req.kind = KIND_FREE;
      if (held_handles.size() != 0) begin
        k = $urandom_range(0, held_handles.size() - 1);
        req.handle_in = held_handles[k];
        held_handles.delete(k);
      end
    end else if (r < 96) begin
      req.kind = KIND_FREE;
    end else if (r < 98) begin
      req.kind = KIND_NOP;
    end else begin
      req.kind = KIND_CLEAR;
    end
    return req;
  endfunction

  // Result check and watchdog
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (done) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with none owed: handle_out %0d failed %0d live_count %0d",
                   $time, result.handle_out, result.failed, result.live_count);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (result.handle_out !== want.handle_out) begin
            $display("%0t: handle_out expected %0d, got %0d",
                     $time, want.handle_out, result.handle_out);
            errors++;
          end
          if (result.failed !== want.failed) begin
            $display("%0t: failed expected %0d, got %0d", $time, want.failed, result.failed);
            errors++;
          end
          if (result.live_count !== want.live_count) begin
            $display("%0t: live_count expected %0d, got %0d",
                     $time, want.live_count, result.live_count);
            errors++;
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    item_t            req;
    logic [CNT_W-1:0] picks [5];
    logic [CNT_W-1:0] mx;
    int               mode;
    int               n;
    int               burst_left;
    bit               no_gaps;

    picks = '{11'd0, 11'd1, 11'd1023, 11'd1024, 11'd2047};

    // Default registers: init 16, max 1024, step 64; handle 0 gets a link early
    plan_chk(KIND_ALLOC, 10'd0,    10'd0,    1'b0, 11'd1);
    plan_chk(KIND_FREE,  10'd0,    10'd0,    1'b0, 11'd0);
    plan_chk(KIND_ALLOC, 10'd0,    10'd0,    1'b0, 11'd1);
    plan_chk(KIND_ALLOC, 10'd0,    10'd1,    1'b0, 11'd2);
    // free of a handle never live is taken unchecked, then reused first
    plan_chk(KIND_FREE,  10'd1023, 10'd0,    1'b0, 11'd1);
    plan_chk(KIND_ALLOC, 10'd0,    10'd1023, 1'b0, 11'd2);
    plan_chk(KIND_NOP,   10'd1023, 10'd0,    1'b0, 11'd2);
    plan_chk(KIND_CLEAR, 10'd1023, 10'd0,    1'b0, 11'd0);
    // free with nothing live
    plan_chk(KIND_FREE,  10'd0,    10'd0,    1'b1, 11'd0);
    // growth by one up to a ceiling of two
    plan_reg(REG_INIT_CAP,  11'd1);
    plan_reg(REG_MAX_CAP,   11'd2);
    plan_reg(REG_GROW_STEP, 11'd1);
    plan_chk(KIND_CLEAR, 10'd0,    10'd0,    1'b0, 11'd0);
    plan_chk(KIND_ALLOC, 10'd0,    10'd0,    1'b0, 11'd1);
    plan_chk(KIND_ALLOC, 10'd0,    10'd1,    1'b0, 11'd2);
    plan_chk(KIND_ALLOC, 10'd0,    10'd0,    1'b1, 11'd2);
    plan_op(KIND_FREE,  10'd1);
    plan_op(KIND_ALLOC, 10'd0);
    // fresh handle beyond a ceiling lowered at run time
    plan_reg(REG_MAX_CAP,  11'd4);
    plan_reg(REG_INIT_CAP, 11'd4);
    plan_chk(KIND_CLEAR, 10'd0,    10'd0,    1'b0, 11'd0);
    plan_chk(KIND_ALLOC, 10'd0,    10'd0,    1'b0, 11'd1);
    plan_chk(KIND_ALLOC, 10'd0,    10'd1,    1'b0, 11'd2);
    plan_reg(REG_MAX_CAP,  11'd1);
    plan_chk(KIND_ALLOC, 10'd0,    10'd0,    1'b1, 11'd2);
    // zero initial capacity: nothing can grow
    plan_reg(REG_INIT_CAP, 11'd0);
    plan_chk(KIND_CLEAR, 10'd0,    10'd0,    1'b0, 11'd0);
    plan_chk(KIND_ALLOC, 10'd0,    10'd0,    1'b1, 11'd0);
    // zero grow step, top ceiling, dropped write to the spare index
    plan_reg(REG_GROW_STEP, 11'd0);
    plan_reg(REG_INIT_CAP,  11'd1);
    plan_reg(REG_MAX_CAP,   11'd2047);
    plan_reg(REG_SPARE,     11'd2047);
    plan_chk(KIND_CLEAR, 10'd0,    10'd0,    1'b0, 11'd0);
    plan_chk(KIND_ALLOC, 10'd0,    10'd0,    1'b0, 11'd1);
    plan_chk(KIND_ALLOC, 10'd0,    10'd0,    1'b1, 11'd1);

    // Reset
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    p_init_cap  = INIT_CAP_RST;
    p_max_cap   = MAX_CAP_RST;
    p_grow_step = GROW_STEP_RST;
    empty_pool();

    // Directed table
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg) wait_idle();
        put_reg(plan[i].idx, plan[i].data);
        if (i + 1 >= plan.size() || !plan[i+1].is_reg) cfg_valid <= 1'b0;
      end else begin
        send_request(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting
    sent_items = 0;
    burst_left = $urandom_range(1, 30);
    while (sent_items < RANDOM_ITEMS) begin
      wait_idle();
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        put_reg(REG_INIT_CAP,  CNT_W'($urandom));
        put_reg(REG_MAX_CAP,   CNT_W'($urandom));
        put_reg(REG_GROW_STEP, CNT_W'($urandom));
      end else if (mode == 1) begin
        put_reg(REG_INIT_CAP,  picks[$urandom_range(0, 4)]);
        put_reg(REG_MAX_CAP,   picks[$urandom_range(0, 4)]);
        put_reg(REG_GROW_STEP, picks[$urandom_range(0, 4)]);
      end else if (mode == 2) begin
        put_reg(REG_INIT_CAP,  INIT_CAP_RST);
        put_reg(REG_MAX_CAP,   MAX_CAP_RST);
        put_reg(REG_GROW_STEP, GROW_STEP_RST);
      end else begin
        // small sizes so that limits, growth and failures are reached
        mx = CNT_W'($urandom_range(1, 48));
        put_reg(REG_MAX_CAP,   mx);
        put_reg(REG_INIT_CAP,  CNT_W'($urandom_range(0, mx + 8)));
        put_reg(REG_GROW_STEP, CNT_W'($urandom_range(0, 12)));
      end
      if ($urandom_range(0, 3) == 0) put_reg(REG_SPARE, CNT_W'($urandom));
      cfg_valid <= 1'b0;

      // most phases start from a clear; the rest keep the old state
      if ($urandom_range(0, 4) != 0) begin
        req = '{kind: KIND_CLEAR,
                handle_in: HANDLE_W'($urandom_range(0, HANDLE_SPACE - 1))};
        send_request(req, 1'b0, '0);
      end

      n = $urandom_range(60, 140);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n; k++) begin
        req = pick_request(((k / 20) % 2 == 0) ? 75 : 30);
        send_request(req, 1'b0, '0);
        if (!no_gaps && burst_left == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
          burst_left = $urandom_range(1, 30);
        end else if (burst_left > 0) begin
          burst_left--;
        end
        // now and then hold off until every result is back
        if ($urandom_range(0, 149) == 0) begin
          start <= 1'b0;
          @(posedge clk);
          while (owed_results.size() != 0) @(posedge clk);
        end
      end
    end

    // Drain
    start <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + 3) @(posedge clk);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
